// File: rtl/clbr_pkg.sv
// Shared types and constants for the circular LED beam renderer.
package clbr_pkg;

    localparam int MAX_LEDS = 1024;

    // shared divider sizes
    localparam int DVD_W = 48;
    localparam int DVS_W = 32;
    localparam int CNT_W = 6;

    // quotient bits per division
    localparam logic [CNT_W-1:0] NB_TIME   = CNT_W'(32);
    localparam logic [CNT_W-1:0] NB_POS    = CNT_W'(33);
    localparam logic [CNT_W-1:0] NB_BOUND  = CNT_W'(30);
    localparam logic [CNT_W-1:0] NB_CENTRE = CNT_W'(26);
    localparam logic [CNT_W-1:0] NB_CHAN   = CNT_W'(8);

    // selectors: window bound or color channel
    localparam logic [1:0] SEL_LO   = 2'd0;
    localparam logic [1:0] SEL_HI   = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        REG_RING_RANGE   = 3'd0,
        REG_MIN_COORD    = 3'd1,
        REG_MAX_COORD    = 3'd2,
        REG_TIME_DIVISOR = 3'd3,
        REG_PHASE_OFFSET = 3'd4,
        REG_BEAM_WIDTH   = 3'd5,
        REG_BEAM_COLOR   = 3'd6,
        REG_LED_COUNT    = 3'd7
    } reg_addr_t;

    typedef struct packed {
        logic [15:0] ring_range;
        logic [15:0] min_coord;
        logic [15:0] max_coord;
        logic [15:0] time_divisor;
        logic [15:0] phase_offset;
        logic [15:0] beam_width;
        logic [23:0] beam_color;
        logic [10:0] led_count;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TDIV,
        ST_TWAIT,
        ST_PDIV,
        ST_PWAIT,
        ST_SETPOS,
        ST_BOUNDS,
        ST_BDIV,
        ST_BWAIT,
        ST_BSET,
        ST_XPROD,
        ST_XDIV,
        ST_XWAIT,
        ST_DIST,
        ST_SQUARE,
        ST_CPROD,
        ST_CDIV,
        ST_CWAIT,
        ST_CSET,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TDIV,
        OP_PDIV,
        OP_SETPOS,
        OP_BOUNDS,
        OP_BDIV,
        OP_BSET,
        OP_XPROD,
        OP_XDIV,
        OP_DIST,
        OP_SQUARE,
        OP_CPROD,
        OP_CDIV,
        OP_CSET,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_status_t;

endpackage

// File: rtl/clbr_if.sv
// Valid/ready channel interfaces for input and result words.
interface clbr_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] time_ms;
    logic [9:0]  pixel_index;

    modport source (output valid, output action, output time_ms, output pixel_index,
                    input ready);
    modport sink (input valid, input action, input time_ms, input pixel_index,
                  output ready);
endinterface

interface clbr_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink (input valid, input pixel_color, output ready);
endinterface

// File: rtl/clbr_div.sv
// Restoring divider, one quotient bit per cycle.
module clbr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [clbr_pkg::DVD_W-1:0]  dividend,
    input  logic [clbr_pkg::DVS_W-1:0]  divisor,
    input  logic [clbr_pkg::CNT_W-1:0]  nbits,
    output logic                        busy,
    output logic [clbr_pkg::DVD_W-1:0]  quotient,
    output logic [clbr_pkg::DVS_W-1:0]  remainder
);
    // caller guarantees dividend >> nbits < divisor
    logic [clbr_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [clbr_pkg::DVD_W-1:0] sh_reg, sh_next;
    logic [clbr_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [clbr_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [clbr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [clbr_pkg::DVS_W:0]   trial;
    logic [clbr_pkg::DVS_W:0]   diff;
    logic                       ge;
    logic [clbr_pkg::CNT_W:0]   lshift;

    always_comb
    begin
        trial    = {rem_reg, sh_reg[clbr_pkg::DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        lshift   = (clbr_pkg::CNT_W+1)'(clbr_pkg::DVD_W) - {1'b0, nbits};
        rem_next = rem_reg;
        sh_next  = sh_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = clbr_pkg::DVS_W'(dividend >> nbits);
            sh_next  = dividend << lshift;
            quo_next = '0;
            dvs_next = divisor;
            cnt_next = nbits;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[clbr_pkg::DVS_W-1:0] : trial[clbr_pkg::DVS_W-1:0];
            sh_next  = {sh_reg[clbr_pkg::DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[clbr_pkg::DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// File: rtl/clbr_datapath.sv
// Datapath: beam state, scratch registers, multipliers and the shared divider.
module clbr_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  clbr_pkg::cfg_t         cfg,
    input  clbr_pkg::dp_cmd_t      cmd,
    output clbr_pkg::dp_status_t   status,
    input  logic [31:0]            in_time,
    input  logic [9:0]             in_index,
    output logic [23:0]            color
);
    logic [15:0] pos_reg, pos_next;
    logic [9:0]  first_reg, first_next;
    logic [9:0]  last_reg, last_next;

    logic [31:0]        time_reg;
    logic [9:0]         idx_reg;
    logic signed [30:0] prod_lo_reg, prod_hi_reg;
    logic [25:0]        xprod_reg;
    logic               shown_reg;
    logic [19:0]        d_reg;
    logic               big_reg;
    logic               zero_reg;
    logic [39:0]        num_reg;
    logic [31:0]        den_reg;
    logic [47:0]        cprod_reg;
    logic               sat_reg;
    logic [7:0]         r_reg, g_reg, b_reg;
    logic [23:0]        color_reg;

    logic [15:0] dv_eff, rng_eff;
    logic [10:0] n_eff;

    logic                        div_start;
    logic [clbr_pkg::DVD_W-1:0]  div_dvd;
    logic [clbr_pkg::DVS_W-1:0]  div_dvs;
    logic [clbr_pkg::CNT_W-1:0]  div_nb;
    logic                        div_busy;
    logic [clbr_pkg::DVD_W-1:0]  quo;
    logic [clbr_pkg::DVS_W-1:0]  rem;

    // bounds
    logic signed [18:0] lo_raw, lo_c, hi_raw, hi_c, lo_off, hi_off;
    logic signed [30:0] bprod;
    logic [29:0]        bmag;
    logic signed [31:0] qv;
    logic [9:0]         bidx;
    logic [32:0]        psum;
    // pixel
    logic [26:0]        centre;
    logic signed [27:0] diff;
    logic [26:0]        fabs;
    logic [14:0]        half;
    logic signed [27:0] fs;
    logic               in_beam;
    logic signed [28:0] dsig;
    logic               big;
    logic               shown;
    logic [7:0]         chan;

    always_comb
    begin
        dv_eff  = (cfg.time_divisor == '0) ? 16'd1 : cfg.time_divisor;
        rng_eff = (cfg.ring_range == '0) ? 16'd1 : cfg.ring_range;
        if (cfg.led_count == '0)
            n_eff = 11'd1;
        else if (cfg.led_count > 11'(clbr_pkg::MAX_LEDS))
            n_eff = 11'(clbr_pkg::MAX_LEDS);
        else
            n_eff = cfg.led_count;
    end

    // window bounds around the beam
    always_comb
    begin
        lo_raw = $signed({3'b0, pos_reg}) - $signed({3'b0, cfg.beam_width});
        lo_c   = (lo_raw < 0) ? lo_raw + $signed({3'b0, rng_eff}) : lo_raw;
        hi_raw = $signed({3'b0, pos_reg}) + $signed({3'b0, cfg.beam_width});
        hi_c   = (hi_raw > $signed({3'b0, cfg.max_coord}))
                 ? hi_raw - $signed({3'b0, rng_eff}) : hi_raw;
        lo_off = lo_c - $signed({3'b0, cfg.min_coord});
        hi_off = hi_c - $signed({3'b0, cfg.min_coord});
        bprod  = (cmd.sel == clbr_pkg::SEL_LO) ? prod_lo_reg : prod_hi_reg;
        bmag   = bprod[30] ? 30'(-bprod) : 30'(bprod);
        // truncation toward zero: negate the magnitude quotient
        qv     = bprod[30] ? -$signed({2'b0, quo[29:0]}) : $signed({2'b0, quo[29:0]});
        qv     = (cmd.sel == clbr_pkg::SEL_LO) ? qv - 32'sd1 : qv + 32'sd1;
        if (qv < 0)
            bidx = '0;
        else if (qv >= $signed({21'b0, n_eff}))
            bidx = 10'(n_eff - 11'd1);
        else
            bidx = qv[9:0];
        psum   = {1'b0, quo[31:0]} + {17'b0, cfg.phase_offset};
    end

    // pixel distance
    always_comb
    begin
        if (last_reg > first_reg)
            shown = !(idx_reg < first_reg || idx_reg > last_reg);
        else
            shown = !(idx_reg > first_reg && idx_reg < last_reg);
        centre  = {1'b0, quo[25:0]} + {11'b0, cfg.min_coord};
        diff    = $signed({1'b0, centre}) - $signed({12'b0, pos_reg});
        fabs    = diff[27] ? 27'(-diff) : 27'(diff);
        half    = cfg.ring_range[15:1];
        fs      = (fabs > {12'b0, half})
                  ? $signed({12'b0, half, 1'b0}) - $signed({1'b0, fabs})
                  : $signed({1'b0, fabs});
        in_beam = fs <= $signed({12'b0, cfg.beam_width});
        dsig    = $signed({13'b0, cfg.beam_width}) - 29'(fs);
        // d >= 16w means the square is already at least 256 w^2
        big     = dsig >= $signed({9'b0, cfg.beam_width, 4'b0});
        unique case (cmd.sel)
            clbr_pkg::CH_RED:   chan = cfg.beam_color[23:16];
            clbr_pkg::CH_GREEN: chan = cfg.beam_color[15:8];
            default:            chan = cfg.beam_color[7:0];
        endcase
    end

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        div_nb    = '0;
        case (cmd.op)
            clbr_pkg::OP_TDIV:
            begin
                div_start = 1'b1;
                div_dvd   = clbr_pkg::DVD_W'(time_reg);
                div_dvs   = clbr_pkg::DVS_W'(dv_eff);
                div_nb    = clbr_pkg::NB_TIME;
            end
            clbr_pkg::OP_PDIV:
            begin
                div_start = 1'b1;
                div_dvd   = clbr_pkg::DVD_W'(psum);
                div_dvs   = clbr_pkg::DVS_W'(rng_eff);
                div_nb    = clbr_pkg::NB_POS;
            end
            clbr_pkg::OP_BDIV:
            begin
                div_start = 1'b1;
                div_dvd   = clbr_pkg::DVD_W'(bmag);
                div_dvs   = clbr_pkg::DVS_W'(rng_eff);
                div_nb    = clbr_pkg::NB_BOUND;
            end
            clbr_pkg::OP_XDIV:
            begin
                div_start = 1'b1;
                div_dvd   = clbr_pkg::DVD_W'(xprod_reg);
                div_dvs   = clbr_pkg::DVS_W'(n_eff);
                div_nb    = clbr_pkg::NB_CENTRE;
            end
            clbr_pkg::OP_CDIV:
            begin
                div_start = 1'b1;
                div_dvd   = cprod_reg;
                div_dvs   = den_reg;
                div_nb    = clbr_pkg::NB_CHAN;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    clbr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .nbits     (div_nb),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (cmd.op == clbr_pkg::OP_SETPOS)
            pos_next = rem[15:0];
        if (cmd.op == clbr_pkg::OP_BSET)
        begin
            if (cmd.sel == clbr_pkg::SEL_LO)
                first_next = bidx;
            else
                last_next = bidx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            clbr_pkg::OP_LOAD:
            begin
                time_reg <= in_time;
                idx_reg  <= in_index;
            end
            clbr_pkg::OP_BOUNDS:
            begin
                prod_lo_reg <= 31'(lo_off) * $signed({20'b0, n_eff});
                prod_hi_reg <= 31'(hi_off) * $signed({20'b0, n_eff});
            end
            clbr_pkg::OP_XPROD:
            begin
                xprod_reg <= {16'b0, idx_reg} * {10'b0, cfg.ring_range};
                shown_reg <= shown;
            end
            clbr_pkg::OP_DIST:
            begin
                d_reg    <= dsig[19:0];
                big_reg  <= big;
                zero_reg <= !shown_reg || (cfg.beam_width == '0) || !in_beam;
            end
            clbr_pkg::OP_SQUARE:
            begin
                num_reg <= {20'b0, d_reg} * {20'b0, d_reg};
                den_reg <= {16'b0, cfg.beam_width} * {16'b0, cfg.beam_width};
            end
            clbr_pkg::OP_CPROD:
            begin
                cprod_reg <= {40'b0, chan} * {8'b0, num_reg};
            end
            clbr_pkg::OP_CDIV:
            begin
                sat_reg <= big_reg ? (chan != '0) : (cprod_reg >= {8'b0, den_reg, 8'b0});
            end
            clbr_pkg::OP_CSET:
            begin
                unique case (cmd.sel)
                    clbr_pkg::CH_RED:   r_reg <= sat_reg ? 8'hFF : quo[7:0];
                    clbr_pkg::CH_GREEN: g_reg <= sat_reg ? 8'hFF : quo[7:0];
                    default:            b_reg <= sat_reg ? 8'hFF : quo[7:0];
                endcase
            end
            clbr_pkg::OP_OUT:
            begin
                color_reg <= zero_reg ? 24'd0 : {r_reg, g_reg, b_reg};
            end
            default:
            begin
                color_reg <= color_reg;
            end
        endcase
    end

    assign status.div_busy = div_busy;
    assign color           = color_reg;
endmodule

// File: rtl/clbr_ctrl.sv
// Control state machine: sequences tick and pixel work through the datapath.
module clbr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_action,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output clbr_pkg::dp_cmd_t      cmd,
    input  clbr_pkg::dp_status_t   status
);
    clbr_pkg::state_t state_reg, state_next;
    logic [1:0]       sel_reg, sel_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clbr_pkg::ST_IDLE;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = clbr_pkg::OP_NONE;
        cmd.sel    = sel_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            clbr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = clbr_pkg::OP_LOAD;
                    state_next = in_action ? clbr_pkg::ST_XPROD : clbr_pkg::ST_TDIV;
                end
            end
            clbr_pkg::ST_TDIV:
            begin
                cmd.op     = clbr_pkg::OP_TDIV;
                state_next = clbr_pkg::ST_TWAIT;
            end
            clbr_pkg::ST_TWAIT:
            begin
                if (!status.div_busy)
                    state_next = clbr_pkg::ST_PDIV;
            end
            clbr_pkg::ST_PDIV:
            begin
                cmd.op     = clbr_pkg::OP_PDIV;
                state_next = clbr_pkg::ST_PWAIT;
            end
            clbr_pkg::ST_PWAIT:
            begin
                if (!status.div_busy)
                    state_next = clbr_pkg::ST_SETPOS;
            end
            clbr_pkg::ST_SETPOS:
            begin
                cmd.op     = clbr_pkg::OP_SETPOS;
                state_next = clbr_pkg::ST_BOUNDS;
            end
            clbr_pkg::ST_BOUNDS:
            begin
                cmd.op     = clbr_pkg::OP_BOUNDS;
                sel_next   = clbr_pkg::SEL_LO;
                state_next = clbr_pkg::ST_BDIV;
            end
            clbr_pkg::ST_BDIV:
            begin
                cmd.op     = clbr_pkg::OP_BDIV;
                state_next = clbr_pkg::ST_BWAIT;
            end
            clbr_pkg::ST_BWAIT:
            begin
                if (!status.div_busy)
                    state_next = clbr_pkg::ST_BSET;
            end
            clbr_pkg::ST_BSET:
            begin
                cmd.op = clbr_pkg::OP_BSET;
                if (sel_reg == clbr_pkg::SEL_HI)
                    state_next = clbr_pkg::ST_IDLE;
                else
                begin
                    sel_next   = clbr_pkg::SEL_HI;
                    state_next = clbr_pkg::ST_BDIV;
                end
            end
            clbr_pkg::ST_XPROD:
            begin
                cmd.op     = clbr_pkg::OP_XPROD;
                state_next = clbr_pkg::ST_XDIV;
            end
            clbr_pkg::ST_XDIV:
            begin
                cmd.op     = clbr_pkg::OP_XDIV;
                state_next = clbr_pkg::ST_XWAIT;
            end
            clbr_pkg::ST_XWAIT:
            begin
                if (!status.div_busy)
                    state_next = clbr_pkg::ST_DIST;
            end
            clbr_pkg::ST_DIST:
            begin
                cmd.op     = clbr_pkg::OP_DIST;
                state_next = clbr_pkg::ST_SQUARE;
            end
            clbr_pkg::ST_SQUARE:
            begin
                cmd.op     = clbr_pkg::OP_SQUARE;
                sel_next   = clbr_pkg::CH_RED;
                state_next = clbr_pkg::ST_CPROD;
            end
            clbr_pkg::ST_CPROD:
            begin
                cmd.op     = clbr_pkg::OP_CPROD;
                state_next = clbr_pkg::ST_CDIV;
            end
            clbr_pkg::ST_CDIV:
            begin
                cmd.op     = clbr_pkg::OP_CDIV;
                state_next = clbr_pkg::ST_CWAIT;
            end
            clbr_pkg::ST_CWAIT:
            begin
                if (!status.div_busy)
                    state_next = clbr_pkg::ST_CSET;
            end
            clbr_pkg::ST_CSET:
            begin
                cmd.op = clbr_pkg::OP_CSET;
                if (sel_reg == clbr_pkg::CH_BLUE)
                    state_next = clbr_pkg::ST_OUT;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = clbr_pkg::ST_CPROD;
                end
            end
            clbr_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = clbr_pkg::OP_OUT;
                    out_load   = 1'b1;
                    state_next = clbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clbr_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || out_load;
    end

    assign out_valid = out_valid_reg;
endmodule

// File: rtl/circular_led_beam_renderer.sv
// Top level of the circular LED beam renderer: register port, control and datapath.
//
// A tick word (action 0) moves the beam to (time_ms/time_divisor + phase_offset)
// mod ring_range and recomputes the lit window's first and last LED; it gives
// no result. A pixel word (action 1) returns one 24-bit color for pixel_index.
// One word is worked on at a time. Every division runs on a single shared
// restoring divider that makes one quotient bit per cycle, and that divider
// sets the rate: a tick needs 32-, 33- and two 30-bit divisions, a pixel
// query a 26-bit division for the LED center and three 8-bit divisions,
// one per channel. The next word is taken
// as soon as the previous one is done; a finished color waits in the output
// register and does not hold up the next word unless a second color is ready
// before the first is taken. Registers are written over APB at byte address
// 4*index and should only change while the block is idle.
module circular_led_beam_renderer (
    input  logic              clk,
    input  logic              rst_n,
    clbr_in_if.sink           in_ch,
    clbr_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    clbr_pkg::cfg_t         cfg_reg, cfg_next;
    clbr_pkg::dp_cmd_t      cmd;
    clbr_pkg::dp_status_t   status;
    clbr_pkg::reg_addr_t    addr;
    logic                   wr_en;

    assign addr   = clbr_pkg::reg_addr_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (addr)
                clbr_pkg::REG_RING_RANGE:   cfg_next.ring_range   = pwdata[15:0];
                clbr_pkg::REG_MIN_COORD:    cfg_next.min_coord    = pwdata[15:0];
                clbr_pkg::REG_MAX_COORD:    cfg_next.max_coord    = pwdata[15:0];
                clbr_pkg::REG_TIME_DIVISOR: cfg_next.time_divisor = pwdata[15:0];
                clbr_pkg::REG_PHASE_OFFSET: cfg_next.phase_offset = pwdata[15:0];
                clbr_pkg::REG_BEAM_WIDTH:   cfg_next.beam_width   = pwdata[15:0];
                clbr_pkg::REG_BEAM_COLOR:   cfg_next.beam_color   = pwdata[23:0];
                clbr_pkg::REG_LED_COUNT:    cfg_next.led_count    = pwdata[10:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (addr)
            clbr_pkg::REG_RING_RANGE:   prdata = {16'b0, cfg_reg.ring_range};
            clbr_pkg::REG_MIN_COORD:    prdata = {16'b0, cfg_reg.min_coord};
            clbr_pkg::REG_MAX_COORD:    prdata = {16'b0, cfg_reg.max_coord};
            clbr_pkg::REG_TIME_DIVISOR: prdata = {16'b0, cfg_reg.time_divisor};
            clbr_pkg::REG_PHASE_OFFSET: prdata = {16'b0, cfg_reg.phase_offset};
            clbr_pkg::REG_BEAM_WIDTH:   prdata = {16'b0, cfg_reg.beam_width};
            clbr_pkg::REG_BEAM_COLOR:   prdata = {8'b0, cfg_reg.beam_color};
            clbr_pkg::REG_LED_COUNT:    prdata = {21'b0, cfg_reg.led_count};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_range   <= 16'd1000;
            cfg_reg.min_coord    <= 16'd0;
            cfg_reg.max_coord    <= 16'd1000;
            cfg_reg.time_divisor <= 16'd2;
            cfg_reg.phase_offset <= 16'd0;
            cfg_reg.beam_width   <= 16'd100;
            cfg_reg.beam_color   <= 24'd6553850;
            cfg_reg.led_count    <= 11'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer
    clbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // beam state, arithmetic and the color output register
    clbr_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .in_time  (in_ch.time_ms),
        .in_index (in_ch.pixel_index),
        .color    (out_ch.pixel_color)
    );
endmodule
